@@ rtl/mcls_pkg.sv @@
// Package for the Markov-chain length sampler.
// Holds field widths, request and status codes, sequencer states and shared types.
// No dependencies.
package mcls_pkg;

    localparam int DEF_MAX_STATES = 16;
    localparam int DEF_PROB_BITS  = 16;
    localparam int DEF_LEN_BITS   = 16;

    localparam int IDX_W    = 4;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [FUNC_W-1:0] FUNC_STEP      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_PROB = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_LEN  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVER_ONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_WAIT,
        ST_SCAN_CMP,
        ST_BACK_WAIT,
        ST_BACK_CMP,
        ST_LEN_TAKE,
        ST_LOAD,
        ST_OUT
    } seq_state_t;

    // Flags produced by the shared compare and add unit.
    typedef struct packed {
        logic lt;      // a below b
        logic a_zero;  // a equals zero
        logic over;    // a or a + b above one
    } alu_flags_t;

endpackage

@@ rtl/mcls_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
// Used for the transition table and the state length table; no dependencies.
module mcls_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mcls_alu.sv @@
// Shared compare and add unit of the sampler sequencer.
// Depends on mcls_pkg for the flag struct.
module mcls_alu #(
    parameter int PROB_BITS = mcls_pkg::DEF_PROB_BITS
) (
    input  logic [PROB_BITS:0]   a,
    input  logic [PROB_BITS:0]   b,
    output logic [PROB_BITS+1:0] sum,
    output mcls_pkg::alu_flags_t flags
);

    localparam logic [PROB_BITS+1:0] ONE = (PROB_BITS+2)'(1) << PROB_BITS;

    always_comb begin
        sum          = {1'b0, a} + {1'b0, b};
        flags.lt     = (a < b);
        flags.a_zero = (a == '0);
        flags.over   = ({1'b0, a} > ONE) || (sum > ONE);
    end

endmodule

@@ rtl/markov_chain_length_sampler.sv @@
// Markov-chain packet length sampler, top level.
// Depends on mcls_pkg, mcls_ram and mcls_alu.
//
// Usage: requests arrive on the s_axis channel; s_axis_tuser carries the
// function (step, load probability, load length) and s_axis_tdata the
// operands. Probability loads build a transition table row by row, column
// zero first, keeping a running cumulative bound per row. Length loads set
// the length reported for each state. A step request carries a random
// fraction; the block scans the current row for the first bound not below
// it, steps back over zero-probability entries, enters that state and
// reports its length. Every request produces exactly one result on m_axis.
// The active_states register is written on the cfg channel, always ready,
// and should only be written while no request is in flight.
// Flow: a step scans each entry in a wait and a compare state, steps back
// over zero entries likewise, then takes the length; the pace is set by
// the table memory's registered read feeding the single shared comparator.
// Loads go through the load state, an unused function straight to output.
// Only one request is in flight; s_axis_tready is high only while idle.
// Reset clears the current state and the running sum, empties the output
// register and sets active_states to one; the tables hold nothing until loaded.
// A stalled receiver holds the result in the output register; the next
// request is still taken and waits for the register to free before finishing.
module markov_chain_length_sampler #(
    parameter int MAX_STATES = mcls_pkg::DEF_MAX_STATES,
    parameter int PROB_BITS  = mcls_pkg::DEF_PROB_BITS,
    parameter int LEN_BITS   = mcls_pkg::DEF_LEN_BITS,
    localparam int IN_RAW    = 2 * mcls_pkg::IDX_W + 2 * (PROB_BITS + 1) + LEN_BITS,
    localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = LEN_BITS + mcls_pkg::IDX_W,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcls_pkg::CFG_W-1:0]    cfg_data,      // active_states

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // row_index, col_index, probability, state_length, random_fraction, zero fill
    input  logic [IN_W-1:0]               s_axis_tdata,
    input  logic [mcls_pkg::FUNC_W-1:0]   s_axis_tuser,  // func

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // length_out, next_state, zero fill
    output logic [OUT_W-1:0]              m_axis_tdata,
    output logic [mcls_pkg::STATUS_W-1:0] m_axis_tuser   // status
);

    localparam int SW    = $clog2(MAX_STATES);
    localparam int AW    = $clog2(MAX_STATES * MAX_STATES);
    localparam int PW    = PROB_BITS + 1;
    localparam int IW    = mcls_pkg::IDX_W;
    localparam int OFF_COL  = IW;
    localparam int OFF_PROB = 2 * IW;
    localparam int OFF_LEN  = OFF_PROB + PW;
    localparam int OFF_FRAC = OFF_LEN + LEN_BITS;
    localparam logic [PW-1:0] ONE = {1'b1, {PROB_BITS{1'b0}}};

    // Sequencer and operand registers.
    mcls_pkg::seq_state_t state_reg, state_next;
    logic [mcls_pkg::CFG_W-1:0]    n_reg, n_next;
    logic [SW-1:0]                 cs_reg, cs_next;
    logic [SW-1:0]                 k_reg, k_next;
    logic [PW-1:0]                 run_reg, run_next;
    logic [mcls_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [IW-1:0]                 row_reg, row_next;
    logic [IW-1:0]                 col_reg, col_next;
    logic [PW-1:0]                 prob_reg, prob_next;
    logic [LEN_BITS-1:0]           len_reg, len_next;
    logic [PW-1:0]                 frac_reg, frac_next;
    logic [LEN_BITS-1:0]           res_len_reg, res_len_next;
    logic [mcls_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [LEN_BITS-1:0]           m_len_reg, m_len_next;
    logic [IW-1:0]                 m_state_reg, m_state_next;
    logic [mcls_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    // Memory ports.
    logic                  tbl_we;
    logic [AW-1:0]         tbl_waddr, tbl_raddr;
    logic [2*PW-1:0]       tbl_wdata, tbl_rdata;
    logic [PW-1:0]         rd_prob, rd_bound;
    logic                  len_we;
    logic [LEN_BITS-1:0]   len_rdata;

    // Shared unit operands.
    logic [PW-1:0]         alu_a, alu_b;
    logic [PW:0]           alu_sum;
    mcls_pkg::alu_flags_t  alu_flags;
    logic [PW-1:0]         sum_sat;

    // Each table word holds the probability above its cumulative bound.
    assign rd_prob   = tbl_rdata[2*PW-1:PW];
    assign rd_bound  = tbl_rdata[PW-1:0];
    assign tbl_raddr = AW'(32'(cs_reg) * MAX_STATES + 32'(k_reg));
    assign tbl_waddr = AW'(32'(row_reg) * MAX_STATES + 32'(col_reg));
    assign sum_sat   = alu_flags.over ? ONE : alu_sum[PW-1:0];
    assign tbl_wdata = {prob_reg, sum_sat};

    mcls_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_STATES * MAX_STATES)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    mcls_ram #(
        .WIDTH (LEN_BITS),
        .DEPTH (MAX_STATES)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (SW'(row_reg)),
        .wdata (len_reg),
        .raddr (k_reg),
        .rdata (len_rdata)
    );

    mcls_alu #(
        .PROB_BITS (PROB_BITS)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .flags (alu_flags)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({m_state_reg, m_len_reg});
    assign m_axis_tuser  = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mcls_pkg::ST_IDLE;
            n_reg       <= mcls_pkg::CFG_W'(1);
            cs_reg      <= '0;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            cs_reg      <= cs_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg          <= k_next;
        func_reg       <= func_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        prob_reg       <= prob_next;
        len_reg        <= len_next;
        frac_reg       <= frac_next;
        res_len_reg    <= res_len_next;
        res_status_reg <= res_status_next;
        m_len_reg      <= m_len_next;
        m_state_reg    <= m_state_next;
        m_status_reg   <= m_status_next;
    end

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        cs_next         = cs_reg;
        k_next          = k_reg;
        run_next        = run_reg;
        func_next       = func_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        prob_next       = prob_reg;
        len_next        = len_reg;
        frac_next       = frac_reg;
        res_len_next    = res_len_reg;
        res_status_next = res_status_reg;
        m_len_next      = m_len_reg;
        m_state_next    = m_state_reg;
        m_status_next   = m_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        s_axis_tready   = 1'b0;
        tbl_we          = 1'b0;
        len_we          = 1'b0;
        // The adder side defaults to the load operands: probability plus the
        // running sum, which restarts when column zero is loaded.
        alu_a           = prob_reg;
        alu_b           = (col_reg == '0) ? '0 : run_reg;

        // The register value is clamped into one to MAX_STATES when written.
        if (cfg_valid) begin
            if (cfg_data == '0) begin
                n_next = mcls_pkg::CFG_W'(1);
            end else if (32'(cfg_data) > MAX_STATES) begin
                n_next = mcls_pkg::CFG_W'(MAX_STATES);
            end else begin
                n_next = cfg_data;
            end
        end

        unique case (state_reg)
            mcls_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    func_next       = s_axis_tuser;
                    row_next        = s_axis_tdata[IW-1:0];
                    col_next        = s_axis_tdata[OFF_COL +: IW];
                    prob_next       = s_axis_tdata[OFF_PROB +: PW];
                    len_next        = s_axis_tdata[OFF_LEN +: LEN_BITS];
                    frac_next       = s_axis_tdata[OFF_FRAC +: PW];
                    k_next          = '0;
                    res_len_next    = '0;
                    res_status_next = mcls_pkg::STATUS_OK;
                    unique case (s_axis_tuser)
                        mcls_pkg::FUNC_STEP:      state_next = mcls_pkg::ST_SCAN_WAIT;
                        mcls_pkg::FUNC_LOAD_PROB: state_next = mcls_pkg::ST_LOAD;
                        mcls_pkg::FUNC_LOAD_LEN:  state_next = mcls_pkg::ST_LOAD;
                        default:                  state_next = mcls_pkg::ST_OUT;
                    endcase
                end
            end
            mcls_pkg::ST_SCAN_WAIT: begin
                state_next = mcls_pkg::ST_SCAN_CMP;
            end
            mcls_pkg::ST_SCAN_CMP: begin
                alu_a = rd_bound;
                alu_b = frac_reg;
                // Keep scanning while the bound is below the fraction, up to the
                // last active column; the entry in hand then goes to step back.
                if (alu_flags.lt && (32'(k_reg) + 1 != 32'(n_reg))) begin
                    k_next     = k_reg + SW'(1);
                    state_next = mcls_pkg::ST_SCAN_WAIT;
                end else begin
                    state_next = mcls_pkg::ST_BACK_CMP;
                end
            end
            mcls_pkg::ST_BACK_WAIT: begin
                state_next = mcls_pkg::ST_BACK_CMP;
            end
            mcls_pkg::ST_BACK_CMP: begin
                alu_a = rd_prob;
                if (alu_flags.a_zero && (k_reg != '0)) begin
                    k_next     = k_reg - SW'(1);
                    state_next = mcls_pkg::ST_BACK_WAIT;
                end else begin
                    state_next = mcls_pkg::ST_LEN_TAKE;
                end
            end
            mcls_pkg::ST_LEN_TAKE: begin
                cs_next      = k_reg;
                res_len_next = len_rdata;
                state_next   = mcls_pkg::ST_OUT;
            end
            mcls_pkg::ST_LOAD: begin
                if (func_reg == mcls_pkg::FUNC_LOAD_PROB) begin
                    if ((32'(row_reg) >= 32'(n_reg)) || (32'(col_reg) >= 32'(n_reg))) begin
                        res_status_next = mcls_pkg::STATUS_BAD_INDEX;
                    end else begin
                        tbl_we          = 1'b1;
                        run_next        = sum_sat;
                        res_status_next = alu_flags.over ? mcls_pkg::STATUS_OVER_ONE
                                                         : mcls_pkg::STATUS_OK;
                    end
                end else begin
                    if (32'(row_reg) >= 32'(n_reg)) begin
                        res_status_next = mcls_pkg::STATUS_BAD_INDEX;
                    end else begin
                        len_we = 1'b1;
                    end
                end
                state_next = mcls_pkg::ST_OUT;
            end
            mcls_pkg::ST_OUT: begin
                // Wait here until the output register is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_len_next    = res_len_reg;
                    m_state_next  = IW'(cs_reg);
                    m_status_next = res_status_reg;
                    state_next    = mcls_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcls_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mcls_checker.sv @@
// Port-level checker for the Markov-chain length sampler, bound to the top level.
// Depends on mcls_pkg and markov_chain_length_sampler.
module mcls_checker #(
    parameter int LEN_BITS = mcls_pkg::DEF_LEN_BITS,
    parameter int OUT_W    = 24
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [OUT_W-1:0]              m_axis_tdata,
    input logic [mcls_pkg::STATUS_W-1:0] m_axis_tuser
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Only one request is in flight: taking one makes the block busy.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after a request was taken");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only loads report an error, and loads always report length zero.
    a_error_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != mcls_pkg::STATUS_OK) |->
            (m_axis_tdata[LEN_BITS-1:0] == '0))
        else $error("error status with a nonzero length");

endmodule

bind markov_chain_length_sampler mcls_checker #(
    .LEN_BITS (LEN_BITS),
    .OUT_W    (OUT_W)
) u_mcls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ sim/testbench.sv @@
// Self-checking bench for the Markov-chain packet length sampler.
// Depends on mcls_pkg and the markov_chain_length_sampler RTL with its mcls_ram and mcls_alu.
`timescale 1ns / 1ps

module testbench;
    import mcls_pkg::*;

    localparam int MAX_ST      = 16;
    localparam int IN_W        = 64;
    localparam int OUT_W       = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_NS    = 20_000_000;
    localparam logic [16:0] PROB_ONE = 17'h10000;
    // The fourth function code is not used by the block and must be ignored.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // One request as it travels on s_axis, field by field.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [3:0]        row;
        logic [3:0]        col;
        logic [16:0]       prob;
        logic [15:0]       len;
        logic [16:0]       frac;
    } chain_req_t;

    // One result as it travels on m_axis.
    typedef struct packed {
        logic [15:0]         length;
        logic [3:0]          state;
        logic [STATUS_W-1:0] status;
    } chain_res_t;

    // Every input of the block starts at a known value.
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic [FUNC_W-1:0] s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    markov_chain_length_sampler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    // Our own copy of the chain: transition table, cumulative bounds, lengths,
    // current state, running row sum and the active_states register.
    logic [16:0] prob_tab  [MAX_ST*MAX_ST];
    logic [16:0] bound_tab [MAX_ST*MAX_ST];
    logic [15:0] len_tab   [MAX_ST];
    logic [3:0]  cur_state  = '0;
    logic [17:0] run_sum    = '0;
    logic [4:0]  act_states = 5'd1;

    chain_req_t pending_q[$];     // requests waiting for the driver
    chain_res_t expected_q[$];    // predicted results, oldest first
    chain_req_t offered;          // the request currently on the bus

    int  requests_open  = 0;      // queued but no result seen yet
    int  queued_count   = 0;
    int  mismatch_count = 0;
    int  gen_states     = 1;      // clamped active_states used while generating
    bit  calm           = 1'b0;   // when set, neither side idles
    int  hold_asks      = 0;      // bumped to ask the receiver for a long hold-off
    int  hold_seen      = 0;
    int  hold_left      = 0;

    // Applies one accepted request to our copy of the chain and returns the
    // result the block must give for it.
    function automatic chain_res_t advance_chain(input chain_req_t rq);
        chain_res_t  res;
        int          n;
        int          base;
        int          k;
        logic [17:0] sum;
        res = '0;
        n = act_states;
        if (n < 1) n = 1;
        if (n > MAX_ST) n = MAX_ST;
        case (rq.func)
            FUNC_STEP: begin
                // First bound not below the fraction, else the last active
                // column, then back over zero-probability entries.
                base = cur_state * MAX_ST;
                k = 0;
                while (k < n && bound_tab[base + k] < rq.frac) k++;
                if (k >= n) k = n - 1;
                while (k > 0 && prob_tab[base + k] == 17'd0) k--;
                cur_state  = k[3:0];
                res.length = len_tab[k];
            end
            FUNC_LOAD_PROB: begin
                if (rq.row >= n || rq.col >= n) begin
                    res.status = STATUS_BAD_INDEX;
                end else begin
                    // Column zero starts a new row; any other column continues.
                    if (rq.col == 4'd0) run_sum = '0;
                    sum = run_sum + rq.prob;
                    if (rq.prob > PROB_ONE || sum > PROB_ONE) begin
                        res.status = STATUS_OVER_ONE;
                        sum = PROB_ONE;
                    end
                    prob_tab[rq.row * MAX_ST + rq.col]  = rq.prob;
                    bound_tab[rq.row * MAX_ST + rq.col] = sum[16:0];
                    run_sum = sum;
                end
            end
            FUNC_LOAD_LEN: begin
                if (rq.row >= n) res.status = STATUS_BAD_INDEX;
                else len_tab[rq.row] = rq.len;
            end
            default: ;
        endcase
        res.state = cur_state;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Sender: offers the next pending request, idling at random unless calm.
    // A request stays on the bus until it is accepted.
    always @(posedge aclk) begin : request_driver
        chain_req_t rq;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expected_q.push_back(advance_chain(offered));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
                    rq = pending_q.pop_front();
                    offered       <= rq;
                    s_axis_tdata  <= {6'd0, rq.frac, rq.len, rq.prob, rq.col, rq.row};
                    s_axis_tuser  <= rq.func;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and the
    // block's single request slot and output register fill up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: compares every result with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        chain_res_t exp_res;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result arrived with no request waiting");
                end else begin
                    exp_res = expected_q.pop_front();
                    if (m_axis_tdata[15:0] !== exp_res.length)
                        report_mismatch($sformatf("length_out %0d, expected %0d",
                                                  m_axis_tdata[15:0], exp_res.length));
                    if (m_axis_tdata[19:16] !== exp_res.state)
                        report_mismatch($sformatf("next_state %0d, expected %0d",
                                                  m_axis_tdata[19:16], exp_res.state));
                    if (m_axis_tuser !== exp_res.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser, exp_res.status));
                end
                requests_open--;
            end
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 35);
        end
    end

    // ---- request generation -------------------------------------------------

    // Queues a request; fields the function does not use carry random bits.
    task automatic put_req(input logic [FUNC_W-1:0] func, input int row, input int col,
                           input int prob, input int len, input int frac);
        chain_req_t rq;
        rq.func = func;
        rq.row  = (row  < 0) ? 4'($urandom)  : 4'(row);
        rq.col  = (col  < 0) ? 4'($urandom)  : 4'(col);
        rq.prob = (prob < 0) ? 17'($urandom) : 17'(prob);
        rq.len  = (len  < 0) ? 16'($urandom) : 16'(len);
        rq.frac = (frac < 0) ? 17'($urandom) : 17'(frac);
        pending_q.push_back(rq);
        requests_open++;
        queued_count++;
    endtask

    task automatic put_step(input int frac);
        put_req(FUNC_STEP, -1, -1, -1, -1, frac);
    endtask

    task automatic put_prob(input int row, input int col, input int prob);
        put_req(FUNC_LOAD_PROB, row, col, prob, -1, -1);
    endtask

    task automatic put_len(input int row, input int len);
        put_req(FUNC_LOAD_LEN, row, -1, -1, len, -1);
    endtask

    function automatic int pick_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 16) return 65536;
        if (r < 26) return $urandom_range(65537, 131071);
        return $urandom_range(0, 65536);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        return $urandom_range(0, 65535);
    endfunction

    // A well-formed row: columns in order from zero, sum at most one, with
    // zero entries sprinkled in; now and then an all-zero or short-sum row.
    task automatic load_row(input int row, input int n);
        int remaining;
        int style;
        int p;
        remaining = 65536;
        style = $urandom_range(0, 9);
        for (int c = 0; c < n; c++) begin
            if (style == 0) p = 0;
            else if (c == n - 1) p = (style == 1) ? $urandom_range(0, remaining) : remaining;
            else if ($urandom_range(0, 3) == 0) p = 0;
            else p = $urandom_range(0, remaining);
            remaining -= p;
            put_prob(row, c, p);
        end
    endtask

    task automatic load_table(input int n);
        for (int r = 0; r < n; r++) load_row(r, n);
        for (int r = 0; r < n; r++) put_len(r, pick_length());
    endtask

    // Mostly steps and clean row reloads, the rest noise: stray or broken
    // loads, bad indexes, over-one values and the unused function.
    task automatic random_phase(input int target);
        int start;
        int r;
        int row;
        start = queued_count;
        while (queued_count - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                put_step(pick_fraction());
            end else if (r < 72) begin
                load_row($urandom_range(0, gen_states - 1), gen_states);
            end else if (r < 80) begin
                put_len($urandom_range(0, 15), pick_length());
            end else if (r < 89) begin
                put_prob($urandom_range(0, 15), $urandom_range(0, 15),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 65536));
            end else if (r < 94) begin
                put_req(FUNC_UNUSED, -1, -1, -1, -1, -1);
            end else begin
                // Row filled with large entries, whose sum can run past one.
                row = $urandom_range(0, gen_states - 1);
                for (int c = 0; c < gen_states; c++)
                    put_prob(row, c, $urandom_range(20000, 70000));
            end
        end
    endtask

    task automatic wait_idle();
        while (requests_open > 0) @(posedge aclk);
    endtask

    // Register write, only once every result of the previous phase is back.
    task automatic set_states(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        act_states = value;
        gen_states = (value == 0) ? 1 : ((value > MAX_ST) ? MAX_ST : value);
    endtask

    // ---- test sequence ------------------------------------------------------

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One active state after reset: extremes, over-one entry, bad indexes,
        // fractions above every bound and the unused function.
        put_len(0, 65535);
        put_prob(0, 0, 65536);
        put_step(0);
        put_step(65536);
        put_step(131071);
        put_prob(0, 0, 0);
        put_step(1);
        put_prob(0, 0, 131071);
        put_prob(0, 1, 5);
        put_prob(1, 0, 5);
        put_len(15, 1234);
        put_len(0, 0);
        put_req(FUNC_UNUSED, -1, -1, -1, -1, -1);
        put_step(65535);

        // Full table at the widest setting, so every entry is written from
        // here on whatever the register holds later.
        set_states(5'd16);
        load_table(16);

        // Running sum past one, out-of-order column, and a short row whose
        // chosen last column is zero so the step walks back to column one.
        put_prob(2, 0, 40000);
        put_prob(2, 1, 40000);
        put_prob(2, 7, 3);
        put_prob(0, 0, 0);
        put_prob(0, 1, 30000);
        for (int c = 2; c < 16; c++) put_prob(0, c, 0);
        put_step(40000);

        random_phase(300);

        set_states(5'd0);        // clamps to one state
        random_phase(150);

        set_states(5'd31);       // clamps to the maximum
        hold_asks++;
        random_phase(250);

        set_states(5'd2);
        calm = 1'b1;
        random_phase(250);
        wait_idle();
        calm = 1'b0;

        set_states(5'd1);
        random_phase(100);

        set_states(5'd9);
        random_phase(250);

        set_states(5'($urandom_range(0, 31)));
        random_phase(250);

        wait_idle();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mcls_pkg.sv
rtl/mcls_ram.sv
rtl/mcls_alu.sv
rtl/markov_chain_length_sampler.sv
rtl/mcls_checker.sv
sim/testbench.sv
